// ----- rtl/amd_pkg.sv -----
// Shared types and constants for the AVI movi chunk demultiplexer.
// No dependencies; imported by every module of the block.
package amd_pkg;

    // Chunk ids as they read little-endian from the stream
    localparam logic [31:0] ID_VIDEO = 32'h6364_3030;  // '00dc'
    localparam logic [31:0] ID_AUDIO = 32'h6277_3130;  // '01wb', skipped like any other id
    localparam logic [31:0] ID_INDEX = 32'h3178_6469;  // 'idx1'

    localparam logic [31:0] DEFAULT_MAX_FRAME = 32'd65536;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 2;
    localparam logic [1:0]  CFG_MOVI_SIZE   = 2'd0;
    localparam logic [1:0]  CFG_MAX_FRAME   = 2'd1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_PAD    = 2'd2,
        PH_ENDED  = 2'd3
    } phase_t;

    typedef enum logic {
        CLS_DELIVER = 1'b0,
        CLS_SKIP    = 1'b1
    } chunk_class_t;

    typedef enum logic [1:0] {
        KIND_VIDEO     = 2'd0,
        KIND_DROP      = 2'd1,
        KIND_END_INDEX = 2'd2,
        KIND_END_SIZE  = 2'd3
    } kind_t;

    typedef enum logic {
        FUNC_DATA    = 1'b0,
        FUNC_RESTART = 1'b1
    } func_t;

    // One input transaction
    typedef struct packed {
        func_t      func;
        logic [7:0] data_byte;
    } item_t;

    // One result transaction
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic [31:0] frame_number;
    } result_t;

endpackage

// ----- rtl/amd_in_reg.sv -----
// Input register stage of the movi demultiplexer.
// Depends on amd_pkg for the item type.
module amd_in_reg
    import amd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  down_ready,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    // Refill whenever the held item moves on or the stage is empty
    assign in_ready   = !valid_reg || down_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- rtl/amd_core.sv -----
// Chunk parser: header assembly, chunk classification, payload and pad
// tracking, offset accounting and the configuration registers. Uses amd_pkg.
module amd_core
    import amd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_wdata,
    input  logic                 step,       // item consumed this cycle
    input  item_t                item,
    output logic                 res_valid,
    output result_t              res
);

    // Configuration
    logic [31:0] movi_size_reg;
    logic [31:0] max_frame_reg;

    // Parser state
    phase_t       phase_reg, phase_next;
    logic [63:0]  shift_reg, shift_next;
    logic [2:0]   hcount_reg, hcount_next;
    logic [31:0]  left_reg, left_next;
    chunk_class_t class_reg, class_next;
    logic         pad_reg, pad_next;
    logic [31:0]  offset_reg, offset_next;
    logic [31:0]  frames_reg, frames_next;

    // Decode of the current byte
    logic        restart;
    logic        end_size;
    logic        hdr_done;
    logic [63:0] hdr_full;
    logic [31:0] hdr_id;
    logic [31:0] hdr_size;
    logic        size_zero;
    logic        is_index;
    logic        is_video;
    logic        fits;
    logic [31:0] left_dec;
    logic        body_last;
    logic [31:0] off_hdr;
    logic [31:0] off_chunk;
    logic [32:0] sum_hdr;
    logic [33:0] sum_chunk;

    // Configuration writes; indexes past the list fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            movi_size_reg <= '0;
            max_frame_reg <= DEFAULT_MAX_FRAME;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_MOVI_SIZE: movi_size_reg <= cfg_wdata;
                CFG_MAX_FRAME: max_frame_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Shared decode
    always_comb begin
        restart   = (item.func == FUNC_RESTART);
        end_size  = (hcount_reg == 3'd0) &&
                    ({1'b0, offset_reg} + 33'd8 > {1'b0, movi_size_reg});
        hdr_full  = {item.data_byte, shift_reg[63:8]};
        hdr_id    = hdr_full[31:0];
        hdr_size  = hdr_full[63:32];
        hdr_done  = !end_size && (hcount_reg == 3'd7);
        size_zero = (hdr_size == 32'd0);
        is_index  = (hdr_id == ID_INDEX);
        is_video  = (hdr_id == ID_VIDEO);
        fits      = (hdr_size <= max_frame_reg);
        left_dec  = (left_reg != 32'd0) ? left_reg - 32'd1 : 32'd0;
        body_last = (left_dec == 32'd0);
        // Saturating offset: header only, and header plus payload and pad
        sum_hdr   = {1'b0, offset_reg} + 33'd8;
        off_hdr   = sum_hdr[32] ? 32'hFFFF_FFFF : sum_hdr[31:0];
        sum_chunk = {2'b00, offset_reg} + 34'd8 + {2'b00, hdr_size} +
                    {33'd0, hdr_size[0]};
        off_chunk = (sum_chunk[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum_chunk[31:0];
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (restart) begin
            phase_next = PH_HEADER;
        end else begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (end_size) begin
                        phase_next = PH_ENDED;
                    end else if (hdr_done && !size_zero) begin
                        phase_next = is_index ? PH_ENDED : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (body_last) begin
                        phase_next = pad_reg ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD:   phase_next = PH_HEADER;
                PH_ENDED: phase_next = PH_ENDED;
                default:  phase_next = PH_HEADER;
            endcase
        end
    end

    // Datapath state and result
    always_comb begin
        shift_next  = shift_reg;
        hcount_next = hcount_reg;
        left_next   = left_reg;
        class_next  = class_reg;
        pad_next    = pad_reg;
        offset_next = offset_reg;
        frames_next = frames_reg;
        res_valid   = 1'b0;
        res.kind          = KIND_VIDEO;
        res.payload_byte  = 8'd0;
        res.last_of_frame = 1'b0;
        res.frame_number  = frames_reg;

        if (restart) begin
            shift_next  = '0;
            hcount_next = '0;
            left_next   = '0;
            class_next  = CLS_DELIVER;
            pad_next    = 1'b0;
            offset_next = '0;
            frames_next = '0;
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    if (end_size) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_END_SIZE;
                    end else begin
                        shift_next  = hdr_full;
                        hcount_next = hcount_reg + 3'd1;
                        if (hdr_done) begin
                            if (size_zero) begin
                                offset_next = off_hdr;
                            end else if (is_index) begin
                                offset_next = off_hdr;
                                res_valid   = 1'b1;
                                res.kind    = KIND_END_INDEX;
                            end else begin
                                left_next   = hdr_size;
                                pad_next    = hdr_size[0];
                                offset_next = off_chunk;
                                class_next  = (is_video && fits) ? CLS_DELIVER : CLS_SKIP;
                                if (is_video && !fits) begin
                                    res_valid = 1'b1;
                                    res.kind  = KIND_DROP;
                                end
                            end
                        end
                    end
                end
                PH_BODY: begin
                    left_next = left_dec;
                    if (class_reg == CLS_DELIVER) begin
                        res_valid         = 1'b1;
                        res.payload_byte  = item.data_byte;
                        res.last_of_frame = body_last;
                        if (body_last) begin
                            frames_next = frames_reg + 32'd1;
                        end
                    end
                end
                PH_PAD:  pad_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            shift_reg  <= '0;
            hcount_reg <= '0;
            left_reg   <= '0;
            class_reg  <= CLS_DELIVER;
            pad_reg    <= 1'b0;
            offset_reg <= '0;
            frames_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            hcount_reg <= hcount_next;
            left_reg   <= left_next;
            class_reg  <= class_next;
            pad_reg    <= pad_next;
            offset_reg <= offset_next;
            frames_reg <= frames_next;
        end
    end

    // Frame count moves only on the last byte of a delivered frame or a restart
    a_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        (frames_reg != $past(frames_reg)) && $past(aresetn) |->
            $past(step) && ($past(restart) || ($past(res_valid) && $past(res.last_of_frame))))
        else $error("frame count changed outside a frame end");

    // An ended stream stays ended until a restart
    a_ended: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_ENDED && !restart |=> phase_reg == PH_ENDED)
        else $error("left ended phase without restart");

    // Payload bytes are only produced from the body phase
    a_video_src: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_VIDEO |-> phase_reg == PH_BODY)
        else $error("video byte outside payload phase");

    // Header count is cleared whenever a chunk body begins
    a_hdr_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> hcount_reg == 3'd0)
        else $error("header count not cleared in payload phase");

endmodule

// ----- rtl/amd_out_buf.sv -----
// Two-entry result buffer: decouples the parser from output backpressure
// so one transaction can be taken every cycle while the output accepts. Uses amd_pkg for result_t.
module amd_out_buf
    import amd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    has_room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t    mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop)  rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> has_room)
        else $error("result pushed into full buffer");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("buffer count out of range");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wptr_reg == rptr_reg)
        else $error("pointers disagree with fill level");

endmodule

// ----- rtl/avi_movi_chunk_demux_top.sv -----
// An accepted input transaction is held in the input register; its result is
// registered in the two-entry result buffer, which drives m_*. Throughput: one
// input byte per cycle while the buffer has room, set by the single parser pass.
// Reset: aresetn synchronous, active low; clears parser state, sets
// movi_size to 0 and max_frame_bytes to 65536, empties both stages.
// Top level of the AVI movi chunk demultiplexer; depends on amd_pkg,
// amd_in_reg, amd_core and amd_out_buf.
module avi_movi_chunk_demux_top
    import amd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] func
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [7:0] payload_byte, [39:8] frame_number
    output logic                 m_tlast,   // last_of_frame
    output logic [1:0]           m_tuser    // [1:0] kind
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    has_room;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign cfg_ready = 1'b1;

    assign in_item.func      = func_t'(s_tuser);
    assign in_item.data_byte = s_tdata;

    amd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .down_ready (has_room),
        .item_valid (item_valid),
        .item       (item)
    );

    assign step = item_valid && has_room;

    amd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    amd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step && res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.frame_number, out_res.payload_byte};
    assign m_tlast = out_res.last_of_frame;
    assign m_tuser = out_res.kind;

endmodule
